// ----- rtl/spq_pkg.sv -----
`default_nettype none

package spq_pkg;

   // Number of cells in the chain.
   localparam int unsigned DEPTH = 8;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned PRIO_W = 16;
   localparam int unsigned FILL_W = 4;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // One queue slot as it moves between neighboring cells.
   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] data;
      logic signed [PRIO_W-1:0] prio;
   } slot_type;

   // Broadcast command to all cells.
   typedef struct packed {
      logic                     ins;
      logic                     del;
      logic signed [DATA_W-1:0] data;
      logic signed [PRIO_W-1:0] prio;
   } cmd_type;

endpackage

`default_nettype wire

// ----- rtl/spq_cell.sv -----
`default_nettype none

module spq_cell
   import spq_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cmd_type  cmd,
   input  wire slot_type prev_slot,
   input  wire logic     prev_ahead,
   input  wire slot_type next_slot,
   output slot_type      slot,
   output logic          ahead
);

   logic                     valid_ff, valid_in;
   logic signed [DATA_W-1:0] data_ff, data_in;
   logic signed [PRIO_W-1:0] prio_ff, prio_in;

   // Held entry stays in front of a new one of equal or lower priority.
   assign ahead = valid_ff && (prio_ff >= cmd.prio);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      prio_in  = prio_ff;
      if (cmd.ins && !ahead) begin
         if (prev_ahead) begin
            valid_in = 1'b1;
            data_in  = cmd.data;
            prio_in  = cmd.prio;
         end else begin
            valid_in = prev_slot.valid;
            data_in  = prev_slot.data;
            prio_in  = prev_slot.prio;
         end
      end else if (cmd.del) begin
         valid_in = next_slot.valid;
         data_in  = next_slot.data;
         prio_in  = next_slot.prio;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
      prio_ff <= prio_in;
   end

   assign slot = '{valid: valid_ff, data: data_ff, prio: prio_ff};

endmodule

`default_nettype wire

// ----- rtl/sorted_priority_queue.sv -----
// Sorted priority queue of DEPTH entries (data word plus signed priority), front
// entry highest priority; equal priorities leave in arrival order. The queue is a
// chain of cells: on an insert every cell compares its priority with the new one
// in parallel, keeps, takes the new entry, or takes its left neighbor's entry;
// on a delete every cell takes its right neighbor's entry. Each request beat
// gives exactly one response beat carrying status (done, refused full, refused
// empty), the removed entry on a successful delete (zero otherwise) and the fill
// count after the operation. Throughput is one operation per clock while the
// response side does not stall: the chain's compare and shift are combinational,
// and the response register accepts a new beat in the same cycle its held beat is
// taken. The response is registered and valid in the cycle after request accept.
`default_nettype none

module sorted_priority_queue
   import spq_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic                     req_op,
   input  wire logic signed [DATA_W-1:0] req_data_in,
   input  wire logic signed [PRIO_W-1:0] req_prio_in,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic signed [DATA_W-1:0]      rsp_data_out,
   output logic signed [PRIO_W-1:0]      rsp_prio_out,
   output logic [FILL_W-1:0]             rsp_fill
);

   slot_type   slot_w  [DEPTH];
   logic       ahead_w [DEPTH];
   cmd_type    cmd;
   logic       accept, full, empty;

   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               status_ff, status_in;
   logic signed [DATA_W-1:0] data_out_ff, data_out_in;
   logic signed [PRIO_W-1:0] prio_out_ff, prio_out_in;
   logic [FILL_W-1:0]        fill_ff, fill_in;

   // Take a new beat whenever the response register is free or being drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Cells fill from the front, so the ends tell full and empty.
   assign full  = slot_w[DEPTH-1].valid;
   assign empty = !slot_w[0].valid;

   assign cmd.ins  = accept && (req_op == OP_INSERT) && !full;
   assign cmd.del  = accept && (req_op == OP_DELETE) && !empty;
   assign cmd.data = req_data_in;
   assign cmd.prio = req_prio_in;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      slot_type prev_s, next_s;
      logic     prev_a;
      if (i == 0) begin : g_front
         // Nothing stands ahead of the front cell.
         assign prev_s = '0;
         assign prev_a = 1'b1;
      end else begin : g_mid
         assign prev_s = slot_w[i-1];
         assign prev_a = ahead_w[i-1];
      end
      if (i == DEPTH-1) begin : g_back
         // Drop an empty slot into the back on delete.
         assign next_s = '0;
      end else begin : g_inner
         assign next_s = slot_w[i+1];
      end
      spq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .prev_slot  (prev_s),
         .prev_ahead (prev_a),
         .next_slot  (next_s),
         .slot       (slot_w[i]),
         .ahead      (ahead_w[i])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      data_out_in  = data_out_ff;
      prio_out_in  = prio_out_ff;
      fill_in      = fill_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         status_in    = ST_DONE;
         data_out_in  = '0;
         prio_out_in  = '0;
         if (req_op == OP_INSERT) begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               fill_in = fill_ff + FILL_W'(1);
            end
         end else begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               data_out_in = slot_w[0].data;
               prio_out_in = slot_w[0].prio;
               fill_in     = fill_ff - FILL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         fill_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
      end
      status_ff   <= status_in;
      data_out_ff <= data_out_in;
      prio_out_ff <= prio_out_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_data_out = data_out_ff;
   assign rsp_prio_out = prio_out_ff;
   assign rsp_fill     = fill_ff;

endmodule

`default_nettype wire

// ----- rtl/spq_checker.sv -----
`default_nettype none

module spq_checker
   import spq_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic                     req_op,
   input wire logic signed [DATA_W-1:0] req_data_in,
   input wire logic signed [PRIO_W-1:0] req_prio_in,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic [1:0]               rsp_status,
   input wire logic signed [DATA_W-1:0] rsp_data_out,
   input wire logic signed [PRIO_W-1:0] rsp_prio_out,
   input wire logic [FILL_W-1:0]        rsp_fill
);

   // Hold a response beat until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_fill))
      else $error("response beat dropped or changed while stalled");

   // Every accepted request yields a response on the next cycle.
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request produced no response");

   // A refused insert only happens at full occupancy and returns no entry.
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |->
         rsp_fill == FILL_W'(DEPTH) && rsp_data_out == '0 && rsp_prio_out == '0)
      else $error("full refusal with wrong fill or payload");

   // A refused delete only happens when empty and returns zeros.
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |->
         rsp_fill == '0 && rsp_data_out == '0 && rsp_prio_out == '0)
      else $error("empty refusal with wrong fill or payload");

   // Nothing is pending right after reset.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

`default_nettype wire

// ----- tb/sv/spq_order_checker.sv -----
module spq_order_checker
   import spq_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_ready,
   input  wire logic                     req_op,
   input  wire logic signed [DATA_W-1:0] req_data_in,
   input  wire logic signed [PRIO_W-1:0] req_prio_in,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   input  wire logic [1:0]               rsp_status,
   input  wire logic signed [DATA_W-1:0] rsp_data_out,
   input  wire logic signed [PRIO_W-1:0] rsp_prio_out,
   input  wire logic [FILL_W-1:0]        rsp_fill,
   output int                            mismatch_count,
   output int                            expected_left,
   output int                            beats_checked,
   output int                            inserts_placed,
   output int                            deletes_served,
   output int                            full_refusals,
   output int                            empty_refusals,
   output int                            peak_fill
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      status_type               status;
      logic signed [DATA_W-1:0] data;
      logic signed [PRIO_W-1:0] prio;
      logic [FILL_W-1:0]        fill;
   } outcome_type;

   outcome_type outcome_q[$];

   // Shadow copy of the sorted slots, front at index 0.
   logic signed [DATA_W-1:0] shadow_data [DEPTH];
   logic signed [PRIO_W-1:0] shadow_prio [DEPTH];
   int                       shadow_count;

   task automatic flag_mismatch(string what);
      mismatch_count++;
      $display("[%0t] queue mismatch: %s", $time, what);
   endtask

   function automatic outcome_type apply_queue_op(logic op, logic signed [DATA_W-1:0] data,
                                                  logic signed [PRIO_W-1:0] prio);
      outcome_type r;
      int          pos;
      r.status = ST_DONE;
      r.data   = '0;
      r.prio   = '0;
      if (op == OP_INSERT) begin
         if (shadow_count >= int'(DEPTH)) begin
            r.status = ST_FULL;
         end else begin
            // walk back past every strictly lower priority; equal ones stay ahead
            pos = shadow_count;
            while (pos > 0 && prio > shadow_prio[pos-1]) begin
               shadow_data[pos] = shadow_data[pos-1];
               shadow_prio[pos] = shadow_prio[pos-1];
               pos--;
            end
            shadow_data[pos] = data;
            shadow_prio[pos] = prio;
            shadow_count++;
         end
      end else begin
         if (shadow_count == 0) begin
            r.status = ST_EMPTY;
         end else begin
            r.data = shadow_data[0];
            r.prio = shadow_prio[0];
            for (int k = 1; k < shadow_count; k++) begin
               shadow_data[k-1] = shadow_data[k];
               shadow_prio[k-1] = shadow_prio[k];
            end
            shadow_count--;
         end
      end
      r.fill = FILL_W'(shadow_count);
      return r;
   endfunction

   always @(posedge clock) begin : watch
      outcome_type want;
      if (reset) begin
         outcome_q.delete();
         shadow_count = 0;
      end else begin
         // predict first, so a same-edge response still pairs with the oldest entry
         if (req_valid && req_ready) begin
            want = apply_queue_op(req_op, req_data_in, req_prio_in);
            case (want.status)
               ST_FULL:  full_refusals++;
               ST_EMPTY: empty_refusals++;
               default: begin
                  if (req_op == OP_INSERT) inserts_placed++;
                  else deletes_served++;
               end
            endcase
            if (shadow_count > peak_fill) peak_fill = shadow_count;
            outcome_q.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               flag_mismatch("response beat with no request outstanding");
            end else begin
               want = outcome_q.pop_front();
               beats_checked++;
               if (rsp_status !== want.status)
                  flag_mismatch($sformatf("status got %0d want %0d", rsp_status, want.status));
               if (rsp_data_out !== want.data)
                  flag_mismatch($sformatf("data_out got %h want %h", rsp_data_out, want.data));
               if (rsp_prio_out !== want.prio)
                  flag_mismatch($sformatf("prio_out got %h want %h", rsp_prio_out, want.prio));
               if (rsp_fill !== want.fill)
                  flag_mismatch($sformatf("fill got %0d want %0d", rsp_fill, want.fill));
            end
         end
      end
      expected_left = outcome_q.size();
   end

endmodule

// ----- tb/sv/sorted_priority_queue_tb.sv -----
module sorted_priority_queue_tb;
   import spq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic signed [PRIO_W-1:0] PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};
   localparam logic signed [PRIO_W-1:0] PRIO_MAX = {1'b0, {(PRIO_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic                     req_op;
   logic signed [DATA_W-1:0] req_data_in;
   logic signed [PRIO_W-1:0] req_prio_in;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [1:0]               rsp_status;
   logic signed [DATA_W-1:0] rsp_data_out;
   logic signed [PRIO_W-1:0] rsp_prio_out;
   logic [FILL_W-1:0]        rsp_fill;

   int mismatch_count;
   int expected_left;
   int beats_checked;
   int inserts_placed;
   int deletes_served;
   int full_refusals;
   int empty_refusals;
   int peak_fill;

   // Idle knobs: percent of cycles the sender sits out and the receiver stalls.
   int idle_pct  = 0;
   int stall_pct = 0;
   // Cycles the receiver still has to hold off; loaded by the stimulus, run down below.
   int hold_left = 0;

   always #10 clock = ~clock;

   sorted_priority_queue dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_data_in  (req_data_in),
      .req_prio_in  (req_prio_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_data_out (rsp_data_out),
      .rsp_prio_out (rsp_prio_out),
      .rsp_fill     (rsp_fill)
   );

   spq_order_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_data_in    (req_data_in),
      .req_prio_in    (req_prio_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_data_out   (rsp_data_out),
      .rsp_prio_out   (rsp_prio_out),
      .rsp_fill       (rsp_fill),
      .mismatch_count (mismatch_count),
      .expected_left  (expected_left),
      .beats_checked  (beats_checked),
      .inserts_placed (inserts_placed),
      .deletes_served (deletes_served),
      .full_refusals  (full_refusals),
      .empty_refusals (empty_refusals),
      .peak_fill      (peak_fill)
   );

   // Receiver: a pending hold-off wins over the random stall; either way the
   // decision lands on the falling edge, clear of the sampling edge.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready = 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_ready = (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Offer one request beat and hold it until the block takes it. Valid stays
   // high from one beat to the next unless the sender decides to sit out.
   task automatic offer_beat(logic op, logic signed [DATA_W-1:0] data,
                             logic signed [PRIO_W-1:0] prio);
      @(negedge clock);
      while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_op      = op;
      req_data_in = data;
      req_prio_in = prio;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and wait until every outstanding response has come back.
   task automatic await_drain();
      int waited;
      waited = 0;
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_left != 0 && waited < 5000) begin
         @(negedge clock);
         waited++;
      end
   endtask

   // Priority shapes: a narrow band that piles up equal priorities, the full
   // range, and the corners of the signed range.
   function automatic logic signed [PRIO_W-1:0] pick_prio(int shape);
      case (shape)
         0: return PRIO_W'(int'($urandom_range(0, 3)) - 2);
         1: return PRIO_W'($urandom());
         default: begin
            case ($urandom_range(0, 4))
               0:       return PRIO_MIN;
               1:       return PRIO_MAX;
               2:       return '0;
               3:       return '1;
               default: return PRIO_W'(1);
            endcase
         end
      endcase
   endfunction

   // Random traffic in bursts. Each burst leans toward inserts, deletes or
   // neither, so the queue keeps swinging between full and empty.
   task automatic run_phase(int sender_idle, int receiver_stall, int beats, bit squeeze);
      int done;
      int burst_left;
      int insert_bias;
      int shape;
      logic op;
      @(posedge clock);
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      // long receiver hold-off while the sender keeps pushing: backs up the
      // response path until the request side has to stall
      if (squeeze) hold_left = 40;
      done        = 0;
      burst_left  = 0;
      insert_bias = 50;
      shape       = 1;
      while (done < beats) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(8, 40);
            case ($urandom_range(0, 2))
               0:       insert_bias = 15;
               1:       insert_bias = 50;
               default: insert_bias = 85;
            endcase
            shape = $urandom_range(0, 2);
         end
         op = ($urandom_range(0, 99) < insert_bias) ? OP_INSERT : OP_DELETE;
         offer_beat(op, DATA_W'($urandom()), pick_prio(shape));
         burst_left--;
         done++;
      end
      await_drain();
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_op      = OP_INSERT;
      req_data_in = '0;
      req_prio_in = '0;
      rsp_ready   = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty delete, fill with corner priorities and data (equal
      // priorities at zero, max and min), refused insert on a full queue, then
      // drain past empty with junk in the ignored fields.
      offer_beat(OP_DELETE, DATA_MAX, PRIO_MAX);
      offer_beat(OP_INSERT, DATA_MAX, '0);
      offer_beat(OP_INSERT, DATA_MIN, PRIO_MAX);
      offer_beat(OP_INSERT, '1, PRIO_MIN);
      offer_beat(OP_INSERT, DATA_W'(1), '0);
      offer_beat(OP_INSERT, DATA_W'(2), '0);
      offer_beat(OP_INSERT, DATA_W'(32'hA5A5A5A5), PRIO_MIN);
      offer_beat(OP_INSERT, DATA_W'(32'h5A5A5A5A), PRIO_MAX);
      offer_beat(OP_INSERT, '0, '1);
      offer_beat(OP_INSERT, DATA_W'(32'h0F0F0F0F), PRIO_MAX);
      repeat (int'(DEPTH)) offer_beat(OP_DELETE, '1, PRIO_MIN);
      offer_beat(OP_DELETE, DATA_MIN, '1);
      await_drain();

      run_phase(0, 0, 450, 1'b1);
      run_phase(52, 0, 450, 1'b0);
      run_phase(0, 52, 450, 1'b0);
      run_phase(23, 23, 500, 1'b1);

      // let any stray response show up before the verdict
      repeat (6) @(negedge clock);

      $display("Checked %0d response beats: %0d inserts placed, %0d deletes served.",
               beats_checked, inserts_placed, deletes_served);
      $display("Refused %0d inserts on a full queue and %0d deletes on an empty one; peak fill %0d.",
               full_refusals, empty_refusals, peak_fill);
      if (expected_left != 0) begin
         $display("%0d responses never arrived", expected_left);
      end
      if (mismatch_count == 0 && expected_left == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Hard stop, far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
rtl/spq_checker.sv
tb/sv/spq_order_checker.sv
tb/sv/sorted_priority_queue_tb.sv
